// ===== rtl/core/qssp_pkg.sv =====
// ----------------------------------------------------------------------------
// qssp_pkg
// Shared constants, types and fixed-point helpers for the quintic smoothstep
// profile unit.
// ----------------------------------------------------------------------------
package qssp_pkg;

  localparam int BISECT_STEPS = 24;

  // quotient bits of the x = t / T and u = |num| / |den| dividers
  localparam int Q_BITS   = 24;
  // quotient bits of the rate and accel dividers
  localparam int DER_BITS = 32;

  // register stages from the input register to each path's result register
  localparam int FWD_LAT = Q_BITS + 5 + DER_BITS + 1;
  localparam int INV_LAT = 3 + Q_BITS + 5 * BISECT_STEPS + 3;
  localparam int OUT_LAT = (INV_LAT > FWD_LAT) ? INV_LAT : FWD_LAT;

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;

  localparam logic [1:0] REG_DURATION = 2'd0;
  localparam logic [1:0] REG_START    = 2'd1;
  localparam logic [1:0] REG_FINAL    = 2'd2;

  localparam logic [23:0]        DURATION_RST = 24'd98304;
  localparam logic signed [31:0] START_RST    = 32'sd0;
  localparam logic signed [31:0] FINAL_RST    = -32'sd9227469;

  typedef struct packed {
    logic [24:0]        prog;
    logic [30:0]        rate;
    logic signed [31:0] accel;
  } fwd_res_t;

  // (a * b) >> 24 for Q0.24 operands below one
  function automatic logic [23:0] mul_q24(input logic [23:0] a, input logic [23:0] b);
    logic [47:0] p;
    p = 48'(a) * 48'(b);
    return p[47:24];
  endfunction

  // 10x^3 - 15x^4 + 6x^5 clamped to 0..1
  function automatic logic [24:0] poly_s(input logic [23:0] x3, input logic [23:0] x4,
                                         input logic [23:0] x5);
    logic signed [30:0] s;
    logic [24:0]        r;
    s = 31'sd10 * $signed(31'(x3)) - 31'sd15 * $signed(31'(x4))
      + 31'sd6 * $signed(31'(x5));
    if (s < 0) begin
      r = '0;
    end else if (s > $signed(31'(ONE_Q24))) begin
      r = ONE_Q24;
    end else begin
      r = s[24:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/qssp_fwd.sv =====
// ----------------------------------------------------------------------------
// qssp_fwd
// Forward path: x = t / T, powers of x, smoothstep value and its two time
// derivatives through restoring divider pipelines, one bit per stage.
// ----------------------------------------------------------------------------
module qssp_fwd
  import qssp_pkg::*;
(
  input  logic        clk,
  input  logic [23:0] sample_time,
  input  logic [23:0] move_duration,
  input  logic [47:0] duration_sq,
  output fwd_res_t    result
);

  typedef struct packed {
    logic [24:0] prog;
    logic        rovf;
    logic        aovf;
    logic        neg;
    logic        tz;
    logic        te;
  } side_t;

  // {time zero, at or past end}, flg[k] sits at stage k+1
  logic [1:0]        flg [Q_BITS+4];
  logic [23:0]       xr  [Q_BITS+1];
  logic [Q_BITS-1:0] xq  [Q_BITS+1];

  logic [23:0] p1_x, p1_x2;
  logic [23:0] p2_x, p2_x2, p2_x3;
  logic [23:0] p3_x, p3_x2, p3_x3, p3_x4;
  logic [23:0] p4_x3, p4_x4, p4_x5;
  logic [29:0] p4_n1c;
  logic [31:0] p4_mag;
  logic        p4_neg;

  logic signed [31:0] n1;
  logic signed [34:0] n2;

  logic [23:0]         rr [DER_BITS+1];
  logic [31:0]         rd [DER_BITS+1];
  logic [DER_BITS-1:0] rq [DER_BITS+1];
  logic [47:0]         ar [DER_BITS+1];
  logic [DER_BITS-1:0] aq [DER_BITS+1];
  side_t               sd [DER_BITS+1];

  logic [DER_BITS-1:0] rq_f, aq_f;
  side_t               sd_f;

  assign xr[0] = sample_time;
  assign xq[0] = '0;

  always_ff @(posedge clk) begin
    flg[0] <= {sample_time == '0, sample_time >= move_duration};
    for (int k = 1; k < Q_BITS + 4; k++) begin
      flg[k] <= flg[k-1];
    end
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_xdiv
    logic [24:0] r2;
    logic        ge;
    assign r2 = {xr[i], 1'b0};
    assign ge = r2 >= {1'b0, move_duration};
    always_ff @(posedge clk) begin
      xr[i+1] <= ge ? 24'(r2 - {1'b0, move_duration}) : r2[23:0];
      xq[i+1] <= {xq[i][Q_BITS-2:0], ge};
    end
  end

  // derivative numerators, scaled by 2^24
  always_comb begin
    n1 = 32'sd30 * $signed(32'(p3_x2)) - 32'sd60 * $signed(32'(p3_x3))
       + 32'sd30 * $signed(32'(p3_x4));
    n2 = 35'sd60 * $signed(35'(p3_x)) - 35'sd180 * $signed(35'(p3_x2))
       + 35'sd120 * $signed(35'(p3_x3));
  end

  always_ff @(posedge clk) begin
    p1_x   <= xq[Q_BITS][23:0];
    p1_x2  <= mul_q24(xq[Q_BITS][23:0], xq[Q_BITS][23:0]);
    p2_x   <= p1_x;
    p2_x2  <= p1_x2;
    p2_x3  <= mul_q24(p1_x2, p1_x);
    p3_x   <= p2_x;
    p3_x2  <= p2_x2;
    p3_x3  <= p2_x3;
    p3_x4  <= mul_q24(p2_x3, p2_x);
    p4_x3  <= p3_x3;
    p4_x4  <= p3_x4;
    p4_x5  <= mul_q24(p3_x4, p3_x);
    p4_n1c <= n1[31] ? '0 : n1[29:0];
    p4_neg <= n2[34];
    p4_mag <= n2[34] ? 32'(-n2) : n2[31:0];
  end

  // divider setup: quotients that would not fit are flagged up front
  always_ff @(posedge clk) begin
    rr[0] <= 24'(p4_n1c[29:16]);
    rd[0] <= {p4_n1c[15:0], 16'b0};
    rq[0] <= '0;
    ar[0] <= 48'(p4_mag);
    aq[0] <= '0;
    sd[0].tz   <= flg[Q_BITS+3][1];
    sd[0].te   <= flg[Q_BITS+3][0];
    sd[0].rovf <= 24'(p4_n1c[29:16]) >= move_duration;
    sd[0].aovf <= 48'(p4_mag) >= duration_sq;
    sd[0].neg  <= p4_neg;
    if (flg[Q_BITS+3][1]) begin
      sd[0].prog <= '0;
    end else if (flg[Q_BITS+3][0]) begin
      sd[0].prog <= ONE_Q24;
    end else begin
      sd[0].prog <= poly_s(p4_x3, p4_x4, p4_x5);
    end
  end

  for (genvar i = 0; i < DER_BITS; i++) begin : g_ddiv
    logic [24:0] r2;
    logic        rge;
    logic [48:0] a2;
    logic        age;
    assign r2  = {rr[i], rd[i][31]};
    assign rge = r2 >= {1'b0, move_duration};
    assign a2  = {ar[i], 1'b0};
    assign age = a2 >= {1'b0, duration_sq};
    always_ff @(posedge clk) begin
      rr[i+1] <= rge ? 24'(r2 - {1'b0, move_duration}) : r2[23:0];
      rd[i+1] <= {rd[i][30:0], 1'b0};
      rq[i+1] <= {rq[i][DER_BITS-2:0], rge};
      ar[i+1] <= age ? 48'(a2 - {1'b0, duration_sq}) : a2[47:0];
      aq[i+1] <= {aq[i][DER_BITS-2:0], age};
      sd[i+1] <= sd[i];
    end
  end

  assign rq_f = rq[DER_BITS];
  assign aq_f = aq[DER_BITS];
  assign sd_f = sd[DER_BITS];

  always_ff @(posedge clk) begin
    result.prog <= sd_f.prog;
    if (sd_f.tz || sd_f.te) begin
      result.rate  <= '0;
      result.accel <= '0;
    end else begin
      result.rate <= (sd_f.rovf || rq_f[31]) ? 31'h7FFF_FFFF : rq_f[30:0];
      if (sd_f.neg) begin
        result.accel <= (sd_f.aovf || aq_f > 32'h8000_0000) ? 32'sh8000_0000
                                                            : $signed(32'(-aq_f));
      end else begin
        result.accel <= (sd_f.aovf || aq_f[31]) ? 32'sh7FFF_FFFF : $signed(aq_f);
      end
    end
  end

endmodule

// ===== rtl/core/qssp_inv.sv =====
// ----------------------------------------------------------------------------
// qssp_inv
// Inverse path: normalized position by a restoring divider pipeline, then an
// unrolled bisection of the smoothstep, five stages per step, then x * T.
// ----------------------------------------------------------------------------
module qssp_inv
  import qssp_pkg::*;
(
  input  logic               clk,
  input  logic signed [31:0] position,
  input  logic signed [31:0] start_position,
  input  logic signed [31:0] final_position,
  input  logic [23:0]        move_duration,
  output logic [23:0]        time_estimate
);

  typedef struct packed {
    logic [24:0] lo;
    logic [24:0] hi;
    logic [24:0] u;
    logic [23:0] mid;
    logic [23:0] x2;
    logic [23:0] x3;
    logic [23:0] x4;
    logic [23:0] x5;
  } bis_t;

  // endpoint terms follow the registers directly
  logic signed [32:0] den;
  logic [32:0]        ad;
  logic               den_zero;

  logic signed [32:0] num;
  logic [32:0]        an;
  logic               uz;

  logic [32:0]       ir    [Q_BITS+1];
  logic [Q_BITS-1:0] iq    [Q_BITS+1];
  logic              izero [Q_BITS+1];
  logic              ione  [Q_BITS+1];

  bis_t bs [BISECT_STEPS+1];

  logic [25:0] f_sum;
  logic [24:0] xf;
  logic [48:0] prod;
  logic [24:0] pt;

  always_ff @(posedge clk) begin
    den      <= 33'(final_position) - 33'(start_position);
    ad       <= den[32] ? 33'(-den) : den;
    den_zero <= den == '0;
  end

  always_ff @(posedge clk) begin
    num <= 33'(position) - 33'(start_position);
    an  <= num[32] ? 33'(-num) : num;
    uz  <= (num == '0) || (num[32] != den[32]);
  end

  assign ir[0]    = an;
  assign iq[0]    = '0;
  assign izero[0] = uz;
  assign ione[0]  = an >= ad;

  for (genvar i = 0; i < Q_BITS; i++) begin : g_udiv
    logic [33:0] r2;
    logic        ge;
    assign r2 = {ir[i], 1'b0};
    assign ge = r2 >= {1'b0, ad};
    always_ff @(posedge clk) begin
      ir[i+1]    <= ge ? 33'(r2 - {1'b0, ad}) : r2[32:0];
      iq[i+1]    <= {iq[i][Q_BITS-2:0], ge};
      izero[i+1] <= izero[i];
      ione[i+1]  <= ione[i];
    end
  end

  always_ff @(posedge clk) begin
    bs[0].lo  <= '0;
    bs[0].hi  <= ONE_Q24;
    bs[0].mid <= '0;
    bs[0].x2  <= '0;
    bs[0].x3  <= '0;
    bs[0].x4  <= '0;
    bs[0].x5  <= '0;
    if (izero[Q_BITS]) begin
      bs[0].u <= '0;
    end else if (ione[Q_BITS]) begin
      bs[0].u <= ONE_Q24;
    end else begin
      bs[0].u <= 25'(iq[Q_BITS]);
    end
  end

  for (genvar j = 0; j < BISECT_STEPS; j++) begin : g_step
    bis_t        sa, sb, sc, sd;
    bis_t        na, nb, nc, nd, ne;
    logic [25:0] sum;
    logic [24:0] s;
    always_comb begin
      sum    = 26'(bs[j].lo) + 26'(bs[j].hi);
      na     = bs[j];
      na.mid = sum[24:1];
      na.x2  = mul_q24(sum[24:1], sum[24:1]);
      nb     = sa;
      nb.x3  = mul_q24(sa.x2, sa.mid);
      nc     = sb;
      nc.x4  = mul_q24(sb.x3, sb.mid);
      nd     = sc;
      nd.x5  = mul_q24(sc.x4, sc.mid);
      ne     = sd;
      s      = poly_s(sd.x3, sd.x4, sd.x5);
      if (s < sd.u) begin
        ne.lo = 25'(sd.mid);
      end else begin
        ne.hi = 25'(sd.mid);
      end
    end
    always_ff @(posedge clk) begin
      sa      <= na;
      sb      <= nb;
      sc      <= nc;
      sd      <= nd;
      bs[j+1] <= ne;
    end
  end

  assign f_sum = 26'(bs[BISECT_STEPS].lo) + 26'(bs[BISECT_STEPS].hi);
  assign pt    = prod[48:24];

  always_ff @(posedge clk) begin
    xf   <= f_sum[25:1];
    prod <= 49'(xf) * 49'(move_duration);
    if (den_zero) begin
      time_estimate <= '0;
    end else if (pt > 25'(move_duration)) begin
      time_estimate <= move_duration;
    end else begin
      time_estimate <= pt[23:0];
    end
  end

endmodule

// ===== rtl/core/quintic_smoothstep_profile_unit.sv =====
// ----------------------------------------------------------------------------
// quintic_smoothstep_profile_unit
// Quintic smoothstep profile: forward evaluation with derivatives, and time
// estimate from position by bisection.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// request  in   start, busy            op, sample_time, position
// result   out  done (single cycle)    progress, progress_rate, progress_accel,
//                                      time_estimate
// config   in   cfg_valid, cfg_ready   cfg_index, cfg_data
//
// one request per clock; busy stays low
// result depth is set by the bisection chain of the inverse path at five stages
// per step; forward results are delayed to the same point so results leave in
// request order
// rst clears the valid pipeline and loads the register defaults
// no stalls: done is a one-cycle strobe that the receiver takes as it comes
// ----------------------------------------------------------------------------
module quintic_smoothstep_profile_unit
  import qssp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [23:0]        sample_time,
  input  logic signed [31:0] position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic [24:0]        progress,
  output logic [30:0]        progress_rate,
  output logic signed [31:0] progress_accel,
  output logic [23:0]        time_estimate
);

  localparam int FWD_PAD = OUT_LAT - FWD_LAT;
  localparam int INV_PAD = OUT_LAT - INV_LAT;

  logic [23:0]        move_duration;
  logic signed [31:0] start_position;
  logic signed [31:0] final_position;
  logic [47:0]        duration_sq;

  logic               acc;
  logic [23:0]        t0;
  logic signed [31:0] z0;
  logic               vld    [OUT_LAT+1];
  logic               op_pip [OUT_LAT+1];

  fwd_res_t    fwd_res;
  logic [23:0] inv_res;
  fwd_res_t    fwd_pip [FWD_PAD+1];
  logic [23:0] inv_pip [INV_PAD+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_duration  <= DURATION_RST;
      start_position <= START_RST;
      final_position <= FINAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DURATION: move_duration  <= cfg_data[23:0];
        REG_START:    start_position <= $signed(cfg_data);
        REG_FINAL:    final_position <= $signed(cfg_data);
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    duration_sq <= 48'(move_duration) * 48'(move_duration);
  end

  always_ff @(posedge clk) begin
    t0        <= sample_time;
    z0        <= position;
    op_pip[0] <= op;
    for (int k = 1; k <= OUT_LAT; k++) begin
      op_pip[k] <= op_pip[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= OUT_LAT; k++) begin
        vld[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[0] <= acc;
      for (int k = 1; k <= OUT_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      done <= vld[OUT_LAT];
    end
  end

  qssp_fwd u_fwd (
    .clk          (clk),
    .sample_time  (t0),
    .move_duration(move_duration),
    .duration_sq  (duration_sq),
    .result       (fwd_res)
  );

  qssp_inv u_inv (
    .clk           (clk),
    .position      (z0),
    .start_position(start_position),
    .final_position(final_position),
    .move_duration (move_duration),
    .time_estimate (inv_res)
  );

  // line up both paths at the common output stage
  assign fwd_pip[0] = fwd_res;
  assign inv_pip[0] = inv_res;

  for (genvar k = 1; k <= FWD_PAD; k++) begin : g_fwd_pad
    always_ff @(posedge clk) begin
      fwd_pip[k] <= fwd_pip[k-1];
    end
  end

  for (genvar k = 1; k <= INV_PAD; k++) begin : g_inv_pad
    always_ff @(posedge clk) begin
      inv_pip[k] <= inv_pip[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (op_pip[OUT_LAT]) begin
      progress       <= '0;
      progress_rate  <= '0;
      progress_accel <= '0;
      time_estimate  <= inv_pip[INV_PAD];
    end else begin
      progress       <= fwd_pip[FWD_PAD].prog;
      progress_rate  <= fwd_pip[FWD_PAD].rate;
      progress_accel <= fwd_pip[FWD_PAD].accel;
      time_estimate  <= '0;
    end
  end

  a_done_follows_request: assert property (
    @(posedge clk) disable iff (rst) done |-> $past(acc, OUT_LAT + 2)
  ) else $error("result strobe without a matching request");

  a_one_op_per_result: assert property (
    @(posedge clk) disable iff (rst)
      (done && time_estimate != '0) |->
        (progress == '0 && progress_rate == '0 && progress_accel == '0)
  ) else $error("forward and inverse outputs both nonzero");

  a_progress_range: assert property (
    @(posedge clk) disable iff (rst) done |-> (progress <= ONE_Q24)
  ) else $error("progress above one");

endmodule
